// ----- sv/slnt_pkg.sv -----
// Shared types and codes for the sorted line-number table.
// No dependencies; used by the interfaces, the cell and the top level.
package slnt_pkg;

    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int HANDLE_IO_W = 16;
    localparam int COUNT_IO_W  = 9;

    // operation codes; the fourth code is unused and answers a miss
    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    // what every cell does on the update cycle
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_REMOVE,
        CM_REPLACE
    } t_cell_mode;

    typedef struct packed {
        logic       cmp;
        t_cell_mode mode;
    } t_cell_ctl;

    typedef struct packed {
        logic ge;
        logic eq;
        logic at;
    } t_cell_stat;

endpackage

// ----- sv/slnt_if.sv -----
// Valid/ready channel interfaces for the request and the result words.
// Depends on slnt_pkg for field widths.
interface slnt_in_if;
    logic                             valid;
    logic                             ready;
    logic [slnt_pkg::OP_W-1:0]        operation;
    logic [slnt_pkg::KEY_W-1:0]       key_number;
    logic [slnt_pkg::HANDLE_IO_W-1:0] payload_handle;
    logic                             next_if_absent;

    modport source (
        output valid, operation, key_number, payload_handle, next_if_absent,
        input  ready
    );
    modport sink (
        input  valid, operation, key_number, payload_handle, next_if_absent,
        output ready
    );
endinterface

interface slnt_out_if;
    logic                             valid;
    logic                             ready;
    logic [slnt_pkg::STATUS_W-1:0]    status;
    logic [slnt_pkg::KEY_W-1:0]       hit_key;
    logic [slnt_pkg::HANDLE_IO_W-1:0] hit_handle;
    logic [slnt_pkg::COUNT_IO_W-1:0]  entry_count;

    modport source (
        output valid, status, hit_key, hit_handle, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, hit_key, hit_handle, entry_count,
        output ready
    );
endinterface

// ----- sv/slnt_cell.sv -----
// One table slot: holds a key and a handle, compares against the search key
// and shifts toward either neighbor. Depends on slnt_pkg.
module slnt_cell #(
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  slnt_pkg::t_cell_ctl        i_ctl,
    input  logic [slnt_pkg::KEY_W-1:0] i_key,
    input  logic [HANDLE_WIDTH-1:0]    i_handle,
    input  logic                       i_left_ge,
    input  logic [slnt_pkg::KEY_W-1:0] i_left_key,
    input  logic [HANDLE_WIDTH-1:0]    i_left_handle,
    input  logic [slnt_pkg::KEY_W-1:0] i_right_key,
    input  logic [HANDLE_WIDTH-1:0]    i_right_handle,
    output logic [slnt_pkg::KEY_W-1:0] o_key,
    output logic [HANDLE_WIDTH-1:0]    o_handle,
    output slnt_pkg::t_cell_stat       o_stat
);

    logic [slnt_pkg::KEY_W-1:0] r_key, n_key;
    logic [HANDLE_WIDTH-1:0]    r_handle, n_handle;
    logic                       r_ge, r_eq;
    logic                       ge_now, eq_now, at;

    always_comb begin
        // empty slots count as "greater": they sit past the end of the table
        ge_now   = !i_valid || (r_key >= i_key);
        eq_now   = i_valid && (r_key == i_key);
        at       = r_ge && !i_left_ge;
        n_key    = r_key;
        n_handle = r_handle;
        unique case (i_ctl.mode)
            slnt_pkg::CM_HOLD: ;
            slnt_pkg::CM_INSERT: begin
                if (i_left_ge) begin
                    n_key    = i_left_key;
                    n_handle = i_left_handle;
                end else if (at) begin
                    n_key    = i_key;
                    n_handle = i_handle;
                end
            end
            slnt_pkg::CM_REMOVE: begin
                if (r_ge) begin
                    n_key    = i_right_key;
                    n_handle = i_right_handle;
                end
            end
            slnt_pkg::CM_REPLACE: begin
                if (r_eq) begin
                    n_handle = i_handle;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
        if (!i_rst_n) begin
            r_ge <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_ge <= ge_now;
            r_eq <= eq_now;
        end
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;
    assign o_stat   = '{ge: r_ge, eq: r_eq, at: at};

endmodule

// ----- sv/sorted_line_number_table.sv -----
// Sorted line-number table, top level: a row of slnt_cell slots plus control.
// Depends on slnt_pkg, slnt_in_if / slnt_out_if and slnt_cell.
//
// Usage:
//   i_in carries request words (find, add or replace, remove); o_out carries
//   one result word per request, in order, with status, the matched key and
//   handle, and the entry count after the operation.
//   A request is taken, every slot compares its key in the next cycle (S_CMP),
//   and S_UPD then selects the hit, shifts the row by one slot for an insert
//   or a remove and loads the result register. A new request is taken in the
//   update cycle of the previous one, so the block can take a new request
//   before it is through with the previous one.
//   The result register decouples the two sides: a stalled receiver holds the
//   result word; the next request is still taken and compared, and its update
//   waits until the result register frees up.
//   Reset empties the table (count to zero); slot contents are not cleared
//   since only slots below the count are ever used.
module sorted_line_number_table #(
    parameter int TABLE_DEPTH  = 256,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    slnt_in_if.sink           i_in,
    slnt_out_if.source        o_out
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    slnt_pkg::t_state                  r_state, n_state;
    logic [slnt_pkg::OP_W-1:0]         r_op;
    logic [slnt_pkg::KEY_W-1:0]        r_key;
    logic [HANDLE_WIDTH-1:0]           r_handle;
    logic                              r_after;
    logic [CW-1:0]                     r_count, n_count;

    logic                              r_out_valid;
    logic [slnt_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [slnt_pkg::KEY_W-1:0]        r_hit_key, n_hit_key;
    logic [HANDLE_WIDTH-1:0]           r_hit_handle, n_hit_handle;
    logic [CW-1:0]                     r_out_count;

    logic                              accept, out_free, commit;
    slnt_pkg::t_cell_mode              mode;
    slnt_pkg::t_cell_ctl               cell_ctl;

    logic [slnt_pkg::KEY_W-1:0]        cell_key    [TABLE_DEPTH];
    logic [HANDLE_WIDTH-1:0]           cell_handle [TABLE_DEPTH];
    slnt_pkg::t_cell_stat              cell_stat   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]            cell_valid;
    logic [TABLE_DEPTH-1:0]            cell_hit;
    logic [TABLE_DEPTH-1:0]            cell_eq;

    logic                              any_hit, exact;
    logic [slnt_pkg::KEY_W-1:0]        sel_key;
    logic [HANDLE_WIDTH-1:0]           sel_handle;

    // ---------------------------------------------------------------- cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic                       left_ge;
        logic [slnt_pkg::KEY_W-1:0] left_key, right_key;
        logic [HANDLE_WIDTH-1:0]    left_handle, right_handle;

        if (g == 0) begin : g_first
            assign left_ge     = 1'b0;
            assign left_key    = '0;
            assign left_handle = '0;
        end else begin : g_mid
            assign left_ge     = cell_stat[g-1].ge;
            assign left_key    = cell_key[g-1];
            assign left_handle = cell_handle[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign right_key    = '0;
            assign right_handle = '0;
        end else begin : g_inner
            assign right_key    = cell_key[g+1];
            assign right_handle = cell_handle[g+1];
        end

        assign cell_valid[g] = CW'(g) < r_count;
        assign cell_hit[g]   = cell_stat[g].at && cell_valid[g];
        assign cell_eq[g]    = cell_stat[g].eq;

        slnt_cell #(
            .HANDLE_WIDTH (HANDLE_WIDTH)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_valid        (cell_valid[g]),
            .i_ctl          (cell_ctl),
            .i_key          (r_key),
            .i_handle       (r_handle),
            .i_left_ge      (left_ge),
            .i_left_key     (left_key),
            .i_left_handle  (left_handle),
            .i_right_key    (right_key),
            .i_right_handle (right_handle),
            .o_key          (cell_key[g]),
            .o_handle       (cell_handle[g]),
            .o_stat         (cell_stat[g])
        );
    end

    // at most one slot sits at the lower-bound position, so OR selects it
    always_comb begin
        sel_key    = '0;
        sel_handle = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (cell_hit[k]) begin
                sel_key    = sel_key | cell_key[k];
                sel_handle = sel_handle | cell_handle[k];
            end
        end
    end

    assign any_hit = |cell_hit;
    assign exact   = |cell_eq;

    // -------------------------------------------------------------- control
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == slnt_pkg::S_IDLE)
                     || ((r_state == slnt_pkg::S_UPD) && out_free);
    assign accept     = i_in.valid && i_in.ready;
    assign commit     = (r_state == slnt_pkg::S_UPD) && out_free;

    always_comb begin
        mode         = slnt_pkg::CM_HOLD;
        n_count      = r_count;
        n_status     = slnt_pkg::ST_MISS;
        n_hit_key    = '0;
        n_hit_handle = '0;
        unique case (r_op)
            slnt_pkg::OP_FIND: begin
                if (any_hit && (exact || r_after)) begin
                    n_status     = slnt_pkg::ST_FOUND;
                    n_hit_key    = sel_key;
                    n_hit_handle = sel_handle;
                end
            end
            slnt_pkg::OP_ADD: begin
                if (exact) begin
                    mode         = slnt_pkg::CM_REPLACE;
                    n_status     = slnt_pkg::ST_REPLACED;
                    n_hit_key    = r_key;
                    n_hit_handle = sel_handle;
                end else if (r_count < CW'(TABLE_DEPTH)) begin
                    mode     = slnt_pkg::CM_INSERT;
                    n_status = slnt_pkg::ST_INSERTED;
                    n_count  = r_count + CW'(1);
                end
            end
            slnt_pkg::OP_REMOVE: begin
                if (exact) begin
                    mode         = slnt_pkg::CM_REMOVE;
                    n_status     = slnt_pkg::ST_REMOVED;
                    n_hit_key    = r_key;
                    n_hit_handle = sel_handle;
                    n_count      = r_count - CW'(1);
                end
            end
            default: ;
        endcase
    end

    assign cell_ctl.cmp  = (r_state == slnt_pkg::S_CMP);
    assign cell_ctl.mode = commit ? mode : slnt_pkg::CM_HOLD;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slnt_pkg::S_IDLE: if (accept) n_state = slnt_pkg::S_CMP;
            slnt_pkg::S_CMP:  n_state = slnt_pkg::S_UPD;
            slnt_pkg::S_UPD: begin
                if (accept) begin
                    n_state = slnt_pkg::S_CMP;
                end else if (commit) begin
                    n_state = slnt_pkg::S_IDLE;
                end
            end
            default: n_state = slnt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_in.operation;
            r_key    <= i_in.key_number;
            r_handle <= HANDLE_WIDTH'(i_in.payload_handle);
            r_after  <= i_in.next_if_absent;
        end
        if (commit) begin
            r_status     <= n_status;
            r_hit_key    <= n_hit_key;
            r_hit_handle <= n_hit_handle;
            r_out_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slnt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.hit_key     = r_hit_key;
    assign o_out.hit_handle  = slnt_pkg::HANDLE_IO_W'(r_hit_handle);
    assign o_out.entry_count = slnt_pkg::COUNT_IO_W'(r_out_count);

    // ----------------------------------------------------------- assertions
    a_single_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slnt_pkg::S_UPD) |-> $onehot0(cell_hit))
        else $error("more than one slot claims the lower-bound position");

    a_exact_at_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == slnt_pkg::S_UPD) && exact) |-> any_hit)
        else $error("key match outside the lower-bound slot");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (mode == slnt_pkg::CM_INSERT))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table by one");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_count <= CW'(TABLE_DEPTH)) && o_out.valid)
        else $error("entry count past depth or result lost");

endmodule
